// File: sv/cpf_pkg.sv
// Shared types, constants and helper functions for the CPF check-digit validator.
// Used by cpf_check_digit_validator_unit; depends on nothing else.
package cpf_pkg;

	// Positions within the formatted string "DDD.DDD.DDD-DD".
	localparam int unsigned POS_W = 4;
	localparam logic [POS_W-1:0] STRING_LENGTH = 4'd14;
	localparam logic [POS_W-1:0] DOT_POS_A     = 4'd3;
	localparam logic [POS_W-1:0] DOT_POS_B     = 4'd7;
	localparam logic [POS_W-1:0] HYPHEN_POS    = 4'd11;
	localparam logic [POS_W-1:0] POS_MAX       = 4'd15;
	localparam logic [POS_W-1:0] FIRST_CHECK_POS  = STRING_LENGTH - 4'd2;
	localparam logic [POS_W-1:0] SECOND_CHECK_POS = STRING_LENGTH - 4'd1;

	// Character codes.
	localparam logic [7:0] CHAR_DOT    = 8'h2E;
	localparam logic [7:0] CHAR_HYPHEN = 8'h2D;
	localparam logic [7:0] CHAR_ZERO   = 8'h30;
	localparam logic [7:0] CHAR_NINE   = 8'h39;

	// Check-digit arithmetic.
	localparam logic [3:0] CHECK_MODULUS = 4'd11;
	localparam logic [3:0] FOLD_VALUE    = 4'd10;
	// Reciprocal of the modulus scaled by 2^11; exact for dividends up to 127.
	localparam int unsigned RECIP_SHIFT = 11;
	localparam logic [7:0] RECIP_MULT   = 8'd187;

	// Reason codes reported with each result.
	localparam logic [2:0] FAIL_NONE   = 3'd0;
	localparam logic [2:0] FAIL_LENGTH = 3'd1;
	localparam logic [2:0] FAIL_FORMAT = 3'd2;
	localparam logic [2:0] FAIL_FIRST  = 3'd3;
	localparam logic [2:0] FAIL_SECOND = 3'd4;

	typedef struct packed {
		logic [7:0] character;
		logic       last_char;
	} item_t;

	typedef struct packed {
		logic       is_valid;
		logic [2:0] fail_reason;
	} result_t;

	// Remainder of a 7-bit value modulo 11, by multiplying with the reciprocal.
	function automatic logic [3:0] mod11(input logic [6:0] x);
		logic [14:0] prod;
		logic [3:0]  quot;
		logic [6:0]  rem;
		prod = 15'(x) * 15'(RECIP_MULT);
		quot = prod[RECIP_SHIFT +: 4];
		rem  = x - (7'(quot) * 7'(CHECK_MODULUS));
		return rem[3:0];
	endfunction

	// A remainder of ten counts as zero.
	function automatic logic [3:0] fold(input logic [3:0] r);
		return (r == FOLD_VALUE) ? 4'd0 : r;
	endfunction

	// Index of the digit held at string position p, separators skipped.
	function automatic logic [3:0] digit_index(input logic [POS_W-1:0] p);
		logic [3:0] idx;
		idx = p;
		if (p > DOT_POS_A) idx = idx - 4'd1;
		if (p > DOT_POS_B) idx = idx - 4'd1;
		if (p > HYPHEN_POS) idx = idx - 4'd1;
		return idx;
	endfunction

endpackage

// File: sv/cpf_check_digit_validator_unit.sv
// Top level of the CPF check-digit validator: input register, per-character
// checks and running mod-11 sums, and the result register.
// Depends on cpf_pkg for types, constants and the mod-11 helper functions.

// Usage:
// The item channel (item_valid, item_ready, item) carries one ASCII character
// of a formatted CPF "DDD.DDD.DDD-DD" per transfer, with last_char set on the
// final character. The result channel (result_valid, result_ready, result)
// carries one result per string, only for the character that had last_char
// set; all other characters produce nothing.
// Throughput is one character per cycle while item_ready is high. A transfer on
// the item channel is registered in the input stage; when it retires from there
// its checks and sum updates are applied and, for a last character, the result
// register is loaded, and the result is presented from that register.
// When the receiver stalls, the result register holds its value; the input
// stage keeps accepting ordinary characters, and only stops (item_ready low)
// when a last character waits behind a result that has not yet been taken.
// Reset clears the position counter, the sums, the error flags and both valid
// flags, so the first character after reset starts a new string. After every
// last character the per-string state also returns to zero.
module cpf_check_digit_validator_unit (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_ready,
	input  cpf_pkg::item_t   item,
	output logic            result_valid,
	input  logic            result_ready,
	output cpf_pkg::result_t result
);

	// Input stage.
	logic           valid_s1;
	cpf_pkg::item_t item_s1;

	// Per-string state.
	logic [cpf_pkg::POS_W-1:0] pos_q;
	logic                      format_bad_q;
	logic [3:0]                sum_first_q;
	logic [3:0]                sum_second_q;
	logic                      first_bad_q;

	// Result register.
	logic             result_valid_q;
	cpf_pkg::result_t result_q;

	// Handshake between stages.
	logic out_free;
	logic s1_go;

	// Per-character logic.
	logic [cpf_pkg::POS_W-1:0] pos_next;
	logic       in_range;
	logic       is_digit;
	logic       is_sep;
	logic       fmt_err;
	logic       digit_ok;
	logic [3:0] dval;
	logic [3:0] idx;
	logic [6:0] acc_first;
	logic [6:0] acc_second;
	logic [3:0] sum_first_next;
	logic [3:0] sum_second_next;
	logic       format_bad_next;
	logic       first_bad_next;
	logic       second_bad;
	logic [2:0] reason;

	// The result register can take a new result when it is empty or being emptied.
	assign out_free   = !result_valid_q || result_ready;
	// A character in the input stage retires unless it needs the result register
	// and that register is still occupied.
	assign s1_go      = valid_s1 && (!item_s1.last_char || out_free);
	assign item_ready = !valid_s1 || s1_go;

	always_comb begin
		in_range = pos_q < cpf_pkg::STRING_LENGTH;
		is_digit = (item_s1.character >= cpf_pkg::CHAR_ZERO)
			&& (item_s1.character <= cpf_pkg::CHAR_NINE);
		// For an ASCII digit the value is the low nibble.
		dval     = is_digit ? item_s1.character[3:0] : 4'd0;
		is_sep   = (pos_q == cpf_pkg::DOT_POS_A) || (pos_q == cpf_pkg::DOT_POS_B)
			|| (pos_q == cpf_pkg::HYPHEN_POS);
		idx      = cpf_pkg::digit_index(pos_q);

		if (!in_range) begin
			fmt_err = 1'b0;
		end else if ((pos_q == cpf_pkg::DOT_POS_A) || (pos_q == cpf_pkg::DOT_POS_B)) begin
			fmt_err = item_s1.character != cpf_pkg::CHAR_DOT;
		end else if (pos_q == cpf_pkg::HYPHEN_POS) begin
			fmt_err = item_s1.character != cpf_pkg::CHAR_HYPHEN;
		end else begin
			fmt_err = !is_digit;
		end
		digit_ok = in_range && !is_sep && is_digit;

		// Running sums: digit times weight, added to a remainder below eleven.
		acc_first  = 7'(sum_first_q) + (7'(dval) * (7'(idx) + 7'd1));
		acc_second = 7'(sum_second_q) + (7'(dval) * 7'(idx));

		sum_first_next = (digit_ok && (pos_q < cpf_pkg::FIRST_CHECK_POS))
			? cpf_pkg::mod11(acc_first) : sum_first_q;
		sum_second_next = (digit_ok && (pos_q < cpf_pkg::SECOND_CHECK_POS))
			? cpf_pkg::mod11(acc_second) : sum_second_q;

		format_bad_next = format_bad_q || fmt_err;
		first_bad_next  = first_bad_q || (digit_ok && (pos_q == cpf_pkg::FIRST_CHECK_POS)
			&& (cpf_pkg::fold(sum_first_q) != dval));
		second_bad      = digit_ok && (pos_q == cpf_pkg::SECOND_CHECK_POS)
			&& (cpf_pkg::fold(sum_second_q) != dval);

		priority if (pos_q != cpf_pkg::SECOND_CHECK_POS) begin
			reason = cpf_pkg::FAIL_LENGTH;
		end else if (format_bad_next) begin
			reason = cpf_pkg::FAIL_FORMAT;
		end else if (first_bad_next) begin
			reason = cpf_pkg::FAIL_FIRST;
		end else if (second_bad) begin
			reason = cpf_pkg::FAIL_SECOND;
		end else begin
			reason = cpf_pkg::FAIL_NONE;
		end

		// The position saturates so that an overlong string still reports length.
		pos_next = (pos_q < cpf_pkg::POS_MAX) ? pos_q + 4'd1 : pos_q;
	end

	// Input stage valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	// Input stage payload.
	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	// Per-string state: advances on every retired character and clears after the last.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			format_bad_q <= 1'b0;
			sum_first_q  <= '0;
			sum_second_q <= '0;
			first_bad_q  <= 1'b0;
		end else if (s1_go) begin
			if (item_s1.last_char) begin
				pos_q        <= '0;
				format_bad_q <= 1'b0;
				sum_first_q  <= '0;
				sum_second_q <= '0;
				first_bad_q  <= 1'b0;
			end else begin
				pos_q        <= pos_next;
				format_bad_q <= format_bad_next;
				sum_first_q  <= sum_first_next;
				sum_second_q <= sum_second_next;
				first_bad_q  <= first_bad_next;
			end
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_free) begin
			result_valid_q <= s1_go && item_s1.last_char;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (s1_go && item_s1.last_char) begin
			result_q.is_valid    <= reason == cpf_pkg::FAIL_NONE;
			result_q.fail_reason <= reason;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
